FILE: hdl/assert_macros.svh
// Assertion macros shared by the route table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, muted during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Next-cycle implication checked on every rising clk edge, muted during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dvrt_pkg.sv
// Types, sizes and codes for the distance-vector route table.
package dvrt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W   = 32;
    localparam int METRIC_W = 8;
    localparam logic [METRIC_W-1:0] METRIC_MAX = '1;

    localparam logic FUNC_MERGE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_UNCHANGED = 3'd2,
        ST_FULL      = 3'd3,
        ST_HIT       = 3'd4,
        ST_MISS      = 3'd5
    } status_t;

    // request payload, first field in the highest bits
    typedef struct packed {
        logic [ADDR_W-1:0]   lookup_addr;
        logic [METRIC_W-1:0] adv_metric;
        logic [ADDR_W-1:0]   sender_addr;
        logic [ADDR_W-1:0]   net_mask;
        logic [ADDR_W-1:0]   dest_addr;
    } req_t;

    // one stored route, also the result payload
    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [ADDR_W-1:0]   gateway;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   dest;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t status;
        entry_t  route;
    } res_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } ram_req_t;

endpackage

FILE: hdl/dvrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/dvrt_ctrl.sv
// Scan sequencer: pipelined table walk, merge/lookup decision and write-back.
module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_vld,
    output logic     in_rdy,
    input  logic     in_func,
    input  req_t     in_req,
    output logic     res_vld,
    input  logic     res_rdy,
    output res_t     res,
    output ram_req_t ram_req,
    input  entry_t   rd_ent
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                func_reg, func_next;
    req_t                req_reg, req_next;
    res_t                res_reg, res_next;

    logic                more;
    logic                merge_hit;
    logic                look_hit;
    logic                hit;
    logic                scan_end;
    logic [METRIC_W-1:0] cand;

    assign more      = issue_idx_reg < cnt_reg;
    assign merge_hit = chk_vld_reg && (rd_ent.dest == req_reg.dest_addr)
                       && (rd_ent.mask == req_reg.net_mask);
    assign look_hit  = chk_vld_reg
                       && ((req_reg.lookup_addr & rd_ent.mask) == (rd_ent.dest & rd_ent.mask));
    assign hit       = (func_reg == FUNC_LOOKUP) ? look_hit : merge_hit;
    assign scan_end  = !chk_vld_reg && !more;
    assign cand      = (req_reg.adv_metric == METRIC_MAX) ? METRIC_MAX
                       : req_reg.adv_metric + METRIC_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        issue_idx_next = issue_idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        ram_req        = '0;
        ram_req.wr_data.dest    = req_reg.dest_addr;
        ram_req.wr_data.mask    = req_reg.net_mask;
        ram_req.wr_data.gateway = req_reg.sender_addr;
        ram_req.wr_data.metric  = cand;
        ram_req.rd_addr         = issue_idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_vld)
                begin
                    func_next      = in_func;
                    req_next       = in_req;
                    issue_idx_next = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.route = '0;
                    if (func_reg == FUNC_LOOKUP)
                    begin
                        res_next.status = ST_HIT;
                        res_next.route  = rd_ent;
                    end
                    else if (cand < rd_ent.metric)
                    begin
                        res_next.status = ST_UPDATED;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = chk_idx_reg;
                    end
                    else
                    begin
                        res_next.status = ST_UNCHANGED;
                    end
                    state_next = S_EMIT;
                end
                else if (scan_end)
                begin
                    res_next.route = '0;
                    if (func_reg == FUNC_LOOKUP)
                    begin
                        res_next.status = ST_MISS;
                    end
                    else if (cnt_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        res_next.status = ST_INSERTED;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = cnt_reg[IDX_W-1:0];
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                    state_next = S_EMIT;
                end
                else if (more)
                begin
                    ram_req.rd_en  = 1'b1;
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (res_rdy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            issue_idx_reg <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            func_reg      <= FUNC_MERGE;
            req_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_idx_reg <= issue_idx_next;
            chk_vld_reg   <= chk_vld_next;
            chk_idx_reg   <= chk_idx_next;
            func_reg      <= func_next;
            req_reg       <= req_next;
            res_reg       <= res_next;
        end
    end

    assign in_rdy  = (state_reg == S_IDLE);
    assign res_vld = (state_reg == S_EMIT);
    assign res     = res_reg;

endmodule

FILE: hdl/distance_vector_route_table_top.sv
// Distance-vector route table: top level with route RAM and result register.
//
// Requests enter on s_axis_*: tuser is func (0 merge, 1 lookup), tdata carries
// dest_addr, net_mask, sender_addr, adv_metric and lookup_addr. Every request
// gives exactly one result on m_axis_*: tuser is the status code, tdata the
// matched route (dest, mask, gateway, metric), all zero unless a lookup hit.
// Routes live in a 16-entry RAM read one entry per cycle in table order.
// Without a match, the scan checks every stored route before the result is
// set; a match at entry i ends the scan early, before later entries are read.
// The walk is bound by the single RAM read port, one entry per cycle.
// Only one request is worked on at a time; s_axis_tready rises again once the
// result has moved to the output register, so the next request is taken while
// the previous result still waits for m_axis_tready.
// If the receiver stalls, the result holds and a second finished result waits
// inside the sequencer until the output register frees.
// Reset empties the table (route count zero) and drops any pending result;
// stale RAM contents are never read.
`include "assert_macros.svh"

module distance_vector_route_table_top
    import dvrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // dest_addr, net_mask, sender_addr, adv_metric, lookup_addr
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // route_dest, route_mask, route_gateway, route_metric
    output logic [2:0]   m_axis_tuser   // status
);

    ram_req_t             ram_req;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 res_vld;
    logic                 res_rdy;
    res_t                 res;
    logic                 out_vld_reg, out_vld_next;
    res_t                 out_reg;

    dvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    dvrt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s_axis_tvalid),
        .in_rdy  (s_axis_tready),
        .in_func (s_axis_tuser),
        .in_req  (req_t'(s_axis_tdata)),
        .res_vld (res_vld),
        .res_rdy (res_rdy),
        .res     (res),
        .ram_req (ram_req),
        .rd_ent  (entry_t'(rd_data))
    );

    assign res_rdy = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_vld && res_rdy)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld && res_rdy)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg.route;
    assign m_axis_tuser  = out_reg.status;

    `ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "request accepted while another is in progress")
    `ASSERT_CLK(a_status_code, !m_axis_tvalid || (m_axis_tuser <= ST_MISS),
        "result carries an unknown status code")
    `ASSERT_CLK(a_zero_route, !m_axis_tvalid || (m_axis_tuser == ST_HIT)
        || (m_axis_tdata == '0), "route fields set on a result other than a hit")

endmodule
